>>> src/ess_pkg.sv
package ess_pkg;

   // configuration register widths and address map
   localparam int START_BITS = 47;
   localparam int RATIO_BITS = 48;
   localparam int LEN_BITS   = 25;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_IDX_LSB   = 3;

   localparam logic [1:0] REG_START = 2'd0;
   localparam logic [1:0] REG_RATIO = 2'd1;
   localparam logic [1:0] REG_LEN   = 2'd2;

   localparam logic [START_BITS-1:0] START_RST = '0;
   localparam logic [RATIO_BITS-1:0] RATIO_RST = 48'h8000_0000_0000;
   localparam logic [LEN_BITS-1:0]   LEN_RST   = 25'd48000;

   // item widths
   localparam int REQ_DATA_BITS = 8;
   localparam int INDEX_BITS    = 24;
   localparam int FQ_DEPTH      = 2;

   localparam logic [63:0] HALF_PI_Q61 = 64'h3243_F6A8_885A_308D;

   typedef struct packed {
      logic [START_BITS-1:0] start_increment;
      logic [RATIO_BITS-1:0] growth_ratio;
      logic [LEN_BITS-1:0]   sweep_length;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic restart;
   } fq_type;

   function automatic logic [63:0] mul_q61(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[124:61];
   endfunction

   // shift-and-subtract divide, only evaluated while building the sine table
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // quarter-wave sine entry, Q61 Taylor series, rounded half up
   function automatic logic [31:0] quarter_value(int unsigned j, int unsigned qshift,
                                                 int unsigned sbits);
      logic [63:0] x, x2, term, sum, amp, sh, sl, t, lmask, div;
      int          k;
      lmask = (64'd1 << qshift) - 64'd1;
      x = (HALF_PI_Q61 >> qshift) * 64'(j) + (((HALF_PI_Q61 & lmask) * 64'(j)) >> qshift);
      x2 = mul_q61(x, x);
      term = x;
      sum = x;
      for (k = 1; k <= 30; k++) begin
         if (term != 64'd0) begin
            div = 64'((2 * k) * (2 * k + 1));
            term = udiv64(mul_q61(term, x2), div);
            if ((k & 1) != 0) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
      end
      amp = (64'd1 << (sbits - 1)) - 64'd1;
      sh = sum >> 32;
      sl = sum & 64'hFFFF_FFFF;
      t = amp * sh + ((amp * sl) >> 32) + (64'd1 << 28);
      return 32'(t >> 29);
   endfunction

endpackage

>>> src/exponential_sine_sweep_generator.sv
// channel  direction  handshake              payload
// req      in         req_tvalid/req_tready  tdata[0] restart
// rsp      out        rsp_tvalid/rsp_tready  tdata sample, sample_index; tlast last; tuser done
// csr      in         apb, pready tied high  start_increment, growth_ratio, sweep_length
//
// an item of a running sweep holds off the next one: the step growth multiply is split into
// half-width partial products and a sum stage, and the next item waits for the new step.
// items with no sweep running pass one per cycle while the output does not stall.
// rsp_tvalid rises once an accepted item has passed the table-read and output registers.
// synchronous reset clears sweep state, queue and output valid; registers take reset values.
// a 2-entry input queue and an output register let each side stall independently.
module exponential_sine_sweep_generator #(
   parameter int  COUNT_BITS     = 24,
   parameter int  PHASE_BITS     = 48,
   parameter int  SINE_ADDR_BITS = 12,
   parameter int  SAMPLE_BITS    = 16,
   localparam int TDATA_BITS     = ((SAMPLE_BITS + ess_pkg::INDEX_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ess_pkg::REQ_DATA_BITS-1:0] req_tdata,   // [0] restart
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [TDATA_BITS-1:0]             rsp_tdata,   // sample, sample_index
   output logic                              rsp_tlast,
   output logic                              rsp_tuser,   // done_res
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ess_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [ess_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [ess_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import ess_pkg::*;

   cfg_type cfg;
   fq_type  fq;
   logic    fq_pop;

   ess_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ess_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .fq         (fq),
      .fq_pop     (fq_pop)
   );

   ess_back #(
      .COUNT_BITS     (COUNT_BITS),
      .PHASE_BITS     (PHASE_BITS),
      .SINE_ADDR_BITS (SINE_ADDR_BITS),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .fq         (fq),
      .fq_pop     (fq_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> src/ess_csr.sv
module ess_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ess_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [ess_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [ess_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output ess_pkg::cfg_type                     cfg
);
   import ess_pkg::*;

   logic [START_BITS-1:0] start_ff, start_in;
   logic [RATIO_BITS-1:0] ratio_ff, ratio_in;
   logic [LEN_BITS-1:0]   len_ff, len_in;
   logic [1:0]            idx;
   logic                  wr;

   assign idx = csr_paddr[CSR_ADDR_BITS-1:CSR_IDX_LSB];
   assign wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      start_in = start_ff;
      ratio_in = ratio_ff;
      len_in = len_ff;
      if (wr) begin
         unique case (idx)
            REG_START: start_in = csr_pwdata[START_BITS-1:0];
            REG_RATIO: ratio_in = csr_pwdata[RATIO_BITS-1:0];
            REG_LEN:   len_in = csr_pwdata[LEN_BITS-1:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_START: csr_prdata = CSR_DATA_BITS'(start_ff);
         REG_RATIO: csr_prdata = CSR_DATA_BITS'(ratio_ff);
         REG_LEN:   csr_prdata = CSR_DATA_BITS'(len_ff);
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RST;
         ratio_ff <= RATIO_RST;
         len_ff <= LEN_RST;
      end else begin
         start_ff <= start_in;
         ratio_ff <= ratio_in;
         len_ff <= len_in;
      end
   end

   assign cfg.start_increment = start_ff;
   assign cfg.growth_ratio = ratio_ff;
   assign cfg.sweep_length = len_ff;

endmodule

>>> src/ess_front.sv
module ess_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ess_pkg::REQ_DATA_BITS-1:0]    req_tdata,   // [0] restart
   output ess_pkg::fq_type                      fq,
   input  logic                                 fq_pop
);
   import ess_pkg::*;

   localparam int CNT_BITS = $clog2(FQ_DEPTH + 1);
   localparam int PTR_BITS = $clog2(FQ_DEPTH);

   logic                ent_ff [FQ_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                push;
   logic                pop;

   assign req_tready = (cnt_ff != CNT_BITS'(FQ_DEPTH));
   assign push = req_tvalid & req_tready;
   assign pop = fq_pop & fq.valid;

   assign fq.valid = (cnt_ff != '0);
   assign fq.restart = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push & !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop & !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= req_tdata[0];
      end
   end

endmodule

>>> src/ess_step_mul.sv
module ess_step_mul #(
   parameter int PHASE_BITS = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic [PHASE_BITS-2:0] step,
   input  logic [PHASE_BITS-1:0] ratio,
   output logic                  busy,
   output logic [PHASE_BITS-2:0] next_step
);
   localparam int H  = (PHASE_BITS + 1) / 2;
   localparam int PW = 2 * H;
   localparam int FW = 4 * H;

   logic [PW-1:0] a, b;
   logic [PW-1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [FW-1:0] prod;
   logic          busy_ff;
   logic          sat;

   assign a = PW'(step);
   assign b = PW'(ratio);

   // half-width partial products, summed in the following cycle
   always_ff @(posedge clock) begin
      if (go) begin
         p00_ff <= PW'(a[H-1:0]) * PW'(b[H-1:0]);
         p01_ff <= PW'(a[H-1:0]) * PW'(b[PW-1:H]);
         p10_ff <= PW'(a[PW-1:H]) * PW'(b[H-1:0]);
         p11_ff <= PW'(a[PW-1:H]) * PW'(b[PW-1:H]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= go;
      end
   end

   assign prod = FW'(p00_ff) + (FW'(p01_ff) << H) + (FW'(p10_ff) << H) + (FW'(p11_ff) << PW);

   // step saturates just below half a turn
   assign sat = |prod[FW-1:2*PHASE_BITS-2];
   assign next_step = sat ? '1 : prod[2*PHASE_BITS-3:PHASE_BITS-1];
   assign busy = busy_ff;

endmodule

>>> src/ess_back.sv
module ess_back #(
   parameter int  COUNT_BITS     = 24,
   parameter int  PHASE_BITS     = 48,
   parameter int  SINE_ADDR_BITS = 12,
   parameter int  SAMPLE_BITS    = 16,
   localparam int TDATA_BITS     = ((SAMPLE_BITS + ess_pkg::INDEX_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ess_pkg::cfg_type      cfg,
   input  ess_pkg::fq_type       fq,
   output logic                  fq_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [TDATA_BITS-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);
   import ess_pkg::*;

   localparam int QS   = SINE_ADDR_BITS - 2;
   localparam int QLEN = 1 << QS;
   localparam int SW   = PHASE_BITS - 1;
   localparam int CMPW = (COUNT_BITS + 1 > LEN_BITS) ? COUNT_BITS + 1 : LEN_BITS;
   localparam logic [CMPW-1:0] LEN_CAP = CMPW'(64'd1 << COUNT_BITS);

   // quarter-wave table, mirrored into four quadrants at read time
   logic [SAMPLE_BITS-1:0] qtr_rom [QLEN+1];

   for (genvar g = 0; g <= QLEN; g++) begin : g_rom
      localparam logic [SAMPLE_BITS-1:0] QV = SAMPLE_BITS'(quarter_value(g, QS, SAMPLE_BITS));
      assign qtr_rom[g] = QV;
   end

   logic [PHASE_BITS-1:0]  acc_ff, acc_in;
   logic [SW-1:0]          step_ff, step_in;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                   act_ff, act_in;
   logic                   s1_vld_ff, s1_vld_in;
   logic                   s1_neg_ff, s1_zero_ff, s1_last_ff;
   logic [INDEX_BITS-1:0]  s1_idx_ff;
   logic [SAMPLE_BITS-1:0] rom_ff;
   logic                   out_vld_ff, out_vld_in;
   logic [TDATA_BITS-1:0]  out_data_ff;
   logic                   out_last_ff, out_done_ff;

   logic [PHASE_BITS-1:0]     cur_acc;
   logic [SW-1:0]             cur_step;
   logic [COUNT_BITS-1:0]     cur_cnt;
   logic                      cur_act;
   logic [CMPW-1:0]           len_ext, len_c, cnt_nxt;
   logic                      is_last;
   logic [SINE_ADDR_BITS-1:0] k;
   logic [QS:0]               ridx;
   logic [SAMPLE_BITS-1:0]    samp;
   logic                      out_free, s1_free, fire;
   logic                      mul_go, mul_busy;
   logic [SW-1:0]             mul_next;

   assign out_free = !out_vld_ff | rsp_tready;
   assign s1_free = !s1_vld_ff | out_free;
   // the step recurrence must finish its multiply before the next item is accepted
   assign fire = fq.valid & !mul_busy & s1_free;
   assign fq_pop = fire;

   always_comb begin
      cur_acc = fq.restart ? '0 : acc_ff;
      cur_step = fq.restart ? SW'(cfg.start_increment) : step_ff;
      cur_cnt = fq.restart ? '0 : cnt_ff;
      len_ext = CMPW'(cfg.sweep_length);
      len_c = (len_ext > LEN_CAP) ? LEN_CAP : len_ext;
      cur_act = fq.restart ? (len_c != '0) : act_ff;
      cnt_nxt = CMPW'(cur_cnt) + 1'b1;
      is_last = (cnt_nxt >= len_c);
      k = cur_acc[PHASE_BITS-1 -: SINE_ADDR_BITS];
      ridx = k[SINE_ADDR_BITS-2] ? ((QS+1)'(QLEN) - {1'b0, k[QS-1:0]}) : {1'b0, k[QS-1:0]};
   end

   assign mul_go = fire & cur_act;

   ess_step_mul #(
      .PHASE_BITS(PHASE_BITS)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .go        (mul_go),
      .step      (cur_step),
      .ratio     (PHASE_BITS'(cfg.growth_ratio)),
      .busy      (mul_busy),
      .next_step (mul_next)
   );

   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      act_in = act_ff;
      step_in = mul_busy ? mul_next : step_ff;
      if (fire) begin
         act_in = cur_act & !is_last;
         if (cur_act) begin
            acc_in = cur_acc + PHASE_BITS'(cur_step);
            cnt_in = cur_cnt + 1'b1;
         end
      end
      s1_vld_in = fire | (s1_vld_ff & !out_free);
      out_vld_in = out_free ? s1_vld_ff : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         step_ff <= '0;
         cnt_ff <= '0;
         act_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         step_ff <= step_in;
         cnt_ff <= cnt_in;
         act_ff <= act_in;
         s1_vld_ff <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // table read and item fields, registered together
   always_ff @(posedge clock) begin
      if (fire) begin
         rom_ff <= qtr_rom[ridx];
         s1_neg_ff <= k[SINE_ADDR_BITS-1];
         s1_zero_ff <= !cur_act;
         s1_idx_ff <= cur_act ? INDEX_BITS'(cur_cnt) : '0;
         s1_last_ff <= cur_act & is_last;
      end
   end

   always_comb begin
      if (s1_zero_ff) begin
         samp = '0;
      end else if (s1_neg_ff) begin
         samp = -rom_ff;
      end else begin
         samp = rom_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free & s1_vld_ff) begin
         out_data_ff <= TDATA_BITS'({s1_idx_ff, samp});
         out_last_ff <= s1_last_ff;
         out_done_ff <= s1_zero_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tlast = out_last_ff;
   assign rsp_tuser = out_done_ff;

endmodule
